[design/rnt_pkg.sv]
// Package for the forward NTT block (q = 3457, 768 coefficients).
// Holds widths, modulus constants, the per-lane gain table and the load residue
// function. No dependencies.
package rnt_pkg;

  // Sizes
  localparam int unsigned ROW_COUNT   = 96;
  localparam int unsigned STORE_DEPTH = 8 * ROW_COUNT;
  localparam int unsigned BANK_DEPTH  = 4 * ROW_COUNT;
  localparam int unsigned BANK_AW     = $clog2(BANK_DEPTH);
  localparam int unsigned STEP_W      = $clog2(ROW_COUNT);
  localparam int unsigned POS_W       = 10;
  localparam int unsigned RES_W       = 12;
  localparam int unsigned RAW_W       = 13;

  // Input word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Modulus and transform constants
  localparam logic [RES_W-1:0] Q          = 12'd3457;
  localparam logic [RES_W-1:0] ALPHA_LOW  = 12'd2735;
  localparam logic [RES_W-1:0] ALPHA_HIGH = 12'd723;
  localparam int unsigned      GAIN_LOW   = 22;
  localparam int unsigned      GAIN_HIGH  = 2;
  localparam int unsigned      ROOT_BASE  = 641;

  // Barrett reduction: quotient estimate = (x * BARRETT_M) >> BARRETT_SH
  localparam int unsigned BARRETT_SH = 24;
  localparam int unsigned BARRETT_M  = (1 << BARRETT_SH) / 3457;
  localparam int unsigned PROD_W     = 2 * RES_W;
  localparam int unsigned EST_W      = PROD_W + 13;

  // Modular multiplier latency and the setup / drain counter end value
  localparam int unsigned MM_LAT   = 4;
  localparam int unsigned CNT_LAST = 2 * MM_LAT + 1;
  localparam int unsigned CNT_W    = $clog2(CNT_LAST + 1);

  // Gain g = (br ? 2 : 22) * 641^k mod q, indexed by lane[9:2] = {v, br, u}
  localparam int unsigned GTAB_DEPTH = 256;
  typedef logic [RES_W-1:0] gain_tab_t [GTAB_DEPTH];

  function automatic gain_tab_t build_gain_tab();
    gain_tab_t   tab;
    int unsigned v;
    int unsigned br;
    int unsigned u;
    int unsigned k;
    int unsigned r;
    for (int unsigned idx = 0; idx < GTAB_DEPTH; idx++) begin
      v  = idx >> 2;
      br = (idx >> 1) & 1;
      u  = idx & 1;
      k  = (32 * (v >> 4) + 3 * (2 * (v & 15) + u)) % ROW_COUNT;
      r  = (br != 0) ? GAIN_HIGH : GAIN_LOW;
      for (int unsigned e = 0; e < k; e++) begin
        r = (r * ROOT_BASE) % 3457;
      end
      tab[idx] = r[RES_W-1:0];
    end
    return tab;
  endfunction

  localparam gain_tab_t GAIN_TAB = build_gain_tab();

  // Signed 13-bit coefficient to canonical residue 0..q-1
  function automatic logic [RES_W-1:0] to_residue(logic [RAW_W-1:0] raw);
    logic signed [RAW_W:0] s;
    logic signed [RAW_W:0] t;
    s = {raw[RAW_W-1], raw};
    if (s < 0) begin
      t = s + $signed({2'b00, Q});
      if (t < 0) begin
        t = t + $signed({2'b00, Q});
      end
    end else if (s >= $signed({2'b00, Q})) begin
      t = s - $signed({2'b00, Q});
    end else begin
      t = s;
    end
    return t[RES_W-1:0];
  endfunction

endpackage

[design/rnt_bank.sv]
// One half of the coefficient store: residues, one write and one read port.
// Read data is registered. Depends on rnt_pkg.
module rnt_bank import rnt_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [BANK_AW-1:0] wr_addr_i,
  input  logic [RES_W-1:0]   wr_data_i,
  input  logic               rd_en_i,
  input  logic [BANK_AW-1:0] rd_addr_i,
  output logic [RES_W-1:0]   rd_data_o
);

  logic [RES_W-1:0] mem_q [BANK_DEPTH];
  logic [RES_W-1:0] rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[design/rnt_modmul.sv]
// Pipelined modular multiplier a*b mod 3457 with Barrett reduction.
// One word per cycle. Depends on rnt_pkg.
module rnt_modmul import rnt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RES_W-1:0] a_i,
  input  logic [RES_W-1:0] b_i,
  output logic             valid_o,
  output logic [RES_W-1:0] prod_o
);

  logic [MM_LAT-1:0]  v_q;
  logic [PROD_W-1:0]  p1_q;
  logic [PROD_W-1:0]  p2_q;
  logic [EST_W-1:0]   est;
  logic [RES_W-1:0]   qe_q;
  logic [PROD_W-1:0]  qq;
  logic [RES_W+1:0]   r_d;
  logic [RES_W+1:0]   r_q;
  logic [RES_W-1:0]   out_q;

  // Valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[MM_LAT-2:0], valid_i};
    end
  end

  // Stage 1: full product
  always_ff @(posedge clk_i) begin
    p1_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  // Stage 2: quotient estimate
  assign est = EST_W'(p1_q) * EST_W'(BARRETT_M);

  always_ff @(posedge clk_i) begin
    qe_q <= est[BARRETT_SH +: RES_W];
    p2_q <= p1_q;
  end

  // Stage 3: remainder, below 2q so the low 14 bits are exact
  assign qq  = PROD_W'(qe_q) * PROD_W'(Q);
  assign r_d = p2_q[RES_W+1:0] - qq[RES_W+1:0];

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  // Stage 4: final correction
  always_ff @(posedge clk_i) begin
    if (r_q >= (RES_W+2)'(Q)) begin
      out_q <= RES_W'(r_q - (RES_W+2)'(Q));
    end else begin
      out_q <= r_q[RES_W-1:0];
    end
  end

  assign valid_o = v_q[MM_LAT-1];
  assign prod_o  = out_q;

endmodule

[design/ring_ntt_forward_d4_mod3457.sv]
// Top level of the forward NTT block: load/read control, power chain and MAC.
// Uses rnt_pkg, rnt_bank (two halves of the store) and rnt_modmul (three).
//
// channel | direction | ports                                        | handshake
// --------+-----------+----------------------------------------------+----------------------
// in      | input     | kind_i, position_i, coeff_value_i             | in_valid_i/in_ready_o
// out     | output    | transform_value_o, out_position_o             | out_valid_o/out_ready_i
//
// Back-to-back loads are accepted every cycle while no read is in progress.
// A read runs a setup phase for g^2..g^4, a MAC phase over ROW_COUNT steps
// (one product pair per cycle, set by the single read port of each store half),
// a drain phase, and then loads the output register.
// A read of a lane at 768 or above skips setup, MAC and drain and returns zero.
// The store has no reset and no clearing pass; control state resets asynchronously.
// A waiting result does not block loads; a finished read holds only while the
// output register is still full.
module ring_ntt_forward_d4_mod3457 import rnt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [RAW_W-1:0] coeff_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [RES_W-1:0] transform_value_o,
  output logic [POS_W-1:0] out_position_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [POS_W-1:0]  lane_q;
  logic [RES_W-1:0]  g1_q, g2_q, g3_q, g4_q;
  logic [RES_W-1:0]  acc_q, acc_d;
  logic              out_valid_q;
  logic [RES_W-1:0]  out_value_q;
  logic [POS_W-1:0]  out_pos_q;

  logic              in_acc;
  logic              load_acc, read_acc;
  logic              pos_ok;
  logic              run;
  logic              out_free;
  logic [RES_W-1:0]  load_res;
  logic [BANK_AW-1:0] hi_wr_addr;
  logic [BANK_AW-1:0] rd_addr;
  logic [RES_W-1:0]  lo_rd, hi_rd;

  // Power chain multiplier
  logic              pm_v_in, pm_v_out;
  logic [RES_W-1:0]  pm_a, pm_b, pm_prod;
  logic [RES_W-1:0]  pw_sel;

  // Step pipeline
  logic              s1_v_q;
  logic [RES_W-1:0]  alpha;
  logic              am_v;
  logic [RES_W-1:0]  am_prod;
  logic [RES_W-1:0]  lo_dly_q [MM_LAT];
  logic [RES_W-1:0]  pw_dly_q [MM_LAT+2];
  logic [RES_W:0]    t_sum;
  logic              tv_q;
  logic [RES_W-1:0]  t_q;
  logic              mm_v;
  logic [RES_W-1:0]  mm_prod;
  logic [RES_W:0]    acc_sum;

  // Handshake
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (kind_i == KIND_LOAD);
  assign read_acc   = in_acc && (kind_i == KIND_READ);
  assign pos_ok     = (position_i < POS_W'(STORE_DEPTH));
  assign run        = (state_q == S_RUN);
  assign out_free   = !out_valid_q || out_ready_i;

  // Loads go straight to the store as residues; reads only happen while
  // no word is accepted, so a load and a read never touch the same entry at once
  assign load_res   = to_residue(coeff_value_i);
  assign hi_wr_addr = BANK_AW'(position_i - POS_W'(BANK_DEPTH));
  assign rd_addr    = {step_q, lane_q[1:0]};

  rnt_bank u_bank_lo (
    .clk_i     (clk_i),
    .wr_en_i   (load_acc && (position_i < POS_W'(BANK_DEPTH))),
    .wr_addr_i (position_i[BANK_AW-1:0]),
    .wr_data_i (load_res),
    .rd_en_i   (run),
    .rd_addr_i (rd_addr),
    .rd_data_o (lo_rd)
  );

  rnt_bank u_bank_hi (
    .clk_i     (clk_i),
    .wr_en_i   (load_acc && pos_ok && (position_i >= POS_W'(BANK_DEPTH))),
    .wr_addr_i (hi_wr_addr),
    .wr_data_i (load_res),
    .rd_en_i   (run),
    .rd_addr_i (rd_addr),
    .rd_data_o (hi_rd)
  );

  // Power of g for this step: 1, g, then g^2 and g^3 from setup; the rest chained by g^4
  always_comb begin
    if (step_q < STEP_W'(MM_LAT)) begin
      case (step_q[1:0])
        2'd0:    pw_sel = RES_W'(1);
        2'd1:    pw_sel = g1_q;
        2'd2:    pw_sel = g2_q;
        2'd3:    pw_sel = g3_q;
        default: pw_sel = RES_W'(1);
      endcase
    end else begin
      pw_sel = pm_prod;
    end
  end

  // Power multiplier operands: g^2, g^3, g^4 during setup, the chain during run
  always_comb begin
    pm_v_in = 1'b0;
    pm_a    = g1_q;
    pm_b    = g1_q;
    if (run) begin
      pm_v_in = 1'b1;
      pm_a    = pw_sel;
      pm_b    = g4_q;
    end else if (state_q == S_SETUP) begin
      if (cnt_q == '0) begin
        pm_v_in = 1'b1;
      end else if (cnt_q == CNT_W'(MM_LAT)) begin
        pm_v_in = 1'b1;
        pm_a    = pm_prod;
      end else if (cnt_q == CNT_W'(MM_LAT + 1)) begin
        pm_v_in = 1'b1;
        pm_a    = g2_q;
        pm_b    = g2_q;
      end
    end
  end

  rnt_modmul u_pow_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pm_v_in),
    .a_i     (pm_a),
    .b_i     (pm_b),
    .valid_o (pm_v_out),
    .prod_o  (pm_prod)
  );

  // alpha * hi
  assign alpha = lane_q[3] ? ALPHA_HIGH : ALPHA_LOW;

  rnt_modmul u_alpha_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .a_i     (alpha),
    .b_i     (hi_rd),
    .valid_o (am_v),
    .prod_o  (am_prod)
  );

  // Delay lines: lo waits for alpha*hi, the power waits for t
  always_ff @(posedge clk_i) begin
    lo_dly_q[0] <= lo_rd;
    for (int unsigned j = 1; j < MM_LAT; j++) begin
      lo_dly_q[j] <= lo_dly_q[j-1];
    end
    pw_dly_q[0] <= pw_sel;
    for (int unsigned j = 1; j < MM_LAT + 2; j++) begin
      pw_dly_q[j] <= pw_dly_q[j-1];
    end
  end

  // t = lo + alpha * hi mod q
  assign t_sum = (RES_W+1)'(lo_dly_q[MM_LAT-1]) + (RES_W+1)'(am_prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      tv_q   <= 1'b0;
    end else begin
      s1_v_q <= run;
      tv_q   <= am_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_sum >= (RES_W+1)'(Q)) begin
      t_q <= RES_W'(t_sum - (RES_W+1)'(Q));
    end else begin
      t_q <= t_sum[RES_W-1:0];
    end
  end

  // t * g^i
  rnt_modmul u_mac_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tv_q),
    .a_i     (t_q),
    .b_i     (pw_dly_q[MM_LAT+1]),
    .valid_o (mm_v),
    .prod_o  (mm_prod)
  );

  // Accumulator
  assign acc_sum = (RES_W+1)'(acc_q) + (RES_W+1)'(mm_prod);

  always_comb begin
    acc_d = acc_q;
    if (read_acc) begin
      acc_d = '0;
    end else if (mm_v) begin
      if (acc_sum >= (RES_W+1)'(Q)) begin
        acc_d = RES_W'(acc_sum - (RES_W+1)'(Q));
      end else begin
        acc_d = acc_sum[RES_W-1:0];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        cnt_d  = '0;
        step_d = '0;
        if (read_acc) begin
          state_d = pos_ok ? S_SETUP : S_FIN;
        end
      end
      S_SETUP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CNT_LAST)) begin
          cnt_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(ROW_COUNT - 1)) begin
          step_d  = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CNT_LAST)) begin
          cnt_d   = '0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  // Lane, gain and setup powers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (read_acc) begin
      lane_q <= position_i;
      g1_q   <= GAIN_TAB[position_i[POS_W-1:2]];
    end
    if ((state_q == S_SETUP) && pm_v_out) begin
      if (cnt_q == CNT_W'(MM_LAT)) begin
        g2_q <= pm_prod;
      end
      if (cnt_q == CNT_W'(2 * MM_LAT)) begin
        g3_q <= pm_prod;
      end
      if (cnt_q == CNT_W'(CNT_LAST)) begin
        g4_q <= pm_prod;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_FIN) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && out_free) begin
      out_value_q <= acc_q;
      out_pos_q   <= lane_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign transform_value_o = out_value_q;
  assign out_position_o    = out_pos_q;

endmodule

[design/rnt_checker.sv]
// Port-level checks for the forward NTT block, bound to the top level.
// Depends on rnt_pkg and ring_ntt_forward_d4_mod3457.
module rnt_checker import rnt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             kind_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [RES_W-1:0] transform_value_o,
  input logic [POS_W-1:0] out_position_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(transform_value_o) && $stable(out_position_o))
    else $error("result word changed while stalled");

  // Results are canonical residues
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (transform_value_o < Q))
    else $error("result not reduced below q");

  // Lanes beyond the store read as zero
  a_out_oob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_position_o >= POS_W'(STORE_DEPTH)) |-> (transform_value_o == '0))
    else $error("out-of-range lane gave a nonzero result");

  // Ready is low in the cycle after a read word is accepted
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_READ) |=> !in_ready_o)
    else $error("ready stayed high after a read word");

  // Loads stream with no bubble
  a_load_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_LOAD) |=> in_ready_o)
    else $error("ready dropped after a load word");

endmodule

bind ring_ntt_forward_d4_mod3457 rnt_checker u_rnt_checker (.*);
